@@ rtl/core/mlp_pkg.sv @@
// Shared sizes, types and arithmetic helpers for the ReLU network block.
package mlp_pkg;

	localparam int N_IN = 4;
	localparam int N_HIDDEN = 4;
	localparam int N_OUT = 2;

	localparam int IN_FIELDS = 4;
	localparam int HW_COUNT = N_HIDDEN * N_IN;
	localparam int OW_COUNT = N_OUT * N_HIDDEN;
	localparam int WSTORE_DEPTH = HW_COUNT + OW_COUNT;
	localparam int BSTORE_DEPTH = N_HIDDEN + N_OUT;

	localparam int Q_W = 16;
	localparam int ACT_W = 15;
	localparam int PROD_W = 2 * Q_W;
	localparam int TRUNC = 8;
	localparam int TERM_W = PROD_W - TRUNC;
	localparam int N_FAN = (N_IN > N_HIDDEN) ? N_IN : N_HIDDEN;
	localparam int SUM_W = TERM_W + $clog2(N_FAN + 1);

	localparam int IN_TDATA_W = 88;
	localparam int OUT_TDATA_W = 32;

	typedef logic signed [Q_W-1:0] q88_t;
	typedef logic [ACT_W-1:0] act_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	localparam q88_t ONE_Q88 = 16'sd256;
	localparam sum_t ACT_MAX = SUM_W'(32767);

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_INFER = 1'b1
	} opcode_t;

	function automatic act_t relu_sat(input sum_t v);
		act_t r;
		if (v[SUM_W-1]) begin
			r = '0;
		end else if (v > ACT_MAX) begin
			r = '1;
		end else begin
			r = v[ACT_W-1:0];
		end
		return r;
	endfunction

	function automatic term_t mul_trunc(input q88_t a, input q88_t b);
		logic signed [PROD_W-1:0] p;
		p = PROD_W'(a * b);
		return p[PROD_W-1:TRUNC];
	endfunction

endpackage

@@ rtl/core/mlp_hid_lane.sv @@
// One hidden neuron: registered truncated products, then sum, bias and ReLU.
module mlp_hid_lane
	import mlp_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  q88_t x [N_IN],
	input  q88_t w [N_IN],
	input  q88_t bias,
	output act_t act
);

	term_t prod_s1 [N_IN];
	q88_t bias_s1;
	sum_t sum;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N_IN; i++) begin
				prod_s1[i] <= mul_trunc(w[i], x[i]);
			end
			bias_s1 <= bias;
		end
	end

	always_comb begin
		sum = SUM_W'(bias_s1);
		for (int i = 0; i < N_IN; i++) begin
			sum = sum + SUM_W'(prod_s1[i]);
		end
	end

	assign act = relu_sat(sum);

endmodule

@@ rtl/core/mlp_out_lane.sv @@
// One output neuron: registered truncated products, then sum, bias and ReLU.
module mlp_out_lane
	import mlp_pkg::*;
(
	input  logic clk,
	input  logic en,
	input  act_t hid [N_HIDDEN],
	input  q88_t w [N_HIDDEN],
	input  q88_t bias,
	output act_t act
);

	term_t prod_s3 [N_HIDDEN];
	q88_t bias_s3;
	sum_t sum;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int h = 0; h < N_HIDDEN; h++) begin
				prod_s3[h] <= mul_trunc(w[h], q88_t'({1'b0, hid[h]}));
			end
			bias_s3 <= bias;
		end
	end

	always_comb begin
		sum = SUM_W'(bias_s3);
		for (int h = 0; h < N_HIDDEN; h++) begin
			sum = sum + SUM_W'(prod_s3[h]);
		end
	end

	assign act = relu_sat(sum);

endmodule

@@ rtl/core/mlp_relu_forward_4_4_2_top.sv @@
// Top level of the ReLU network block: parameter store, lanes and output register.
//
// The block accepts one word per cycle while s_tready is high. A write word updates
// the weight or bias store in the cycle it is accepted and affects every inference
// word accepted after it. An inference word reaches the master side through
// registered stages, in order: hidden products, hidden sum and activation, output
// products, then output sum and activation into the output register. Each hidden
// and each output neuron has its own lane of multipliers. When the master side
// stalls, the whole pipeline holds and s_tready drops with it, so throughput stays
// at one word per cycle while m_tready is high.
module mlp_relu_forward_4_4_2_top
	import mlp_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// param_index[4:0], param_value[20:5], in0[36:21], in1[52:37], in2[68:53],
	// in3[84:69], zero padding above.
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// opcode[0].
	input  logic                   s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// out0[14:0], out1[29:15], zero padding above.
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	logic [4:0] param_index;
	q88_t param_value;
	q88_t ins [IN_FIELDS];
	q88_t x [N_IN];

	q88_t w_q [WSTORE_DEPTH];
	q88_t b_q [BSTORE_DEPTH];

	logic adv;
	logic acc_w;
	logic acc_c;
	logic v_s1, v_s2, v_s3, v_s4;

	q88_t ow_s1 [OW_COUNT];
	q88_t ow_s2 [OW_COUNT];
	q88_t ob_s1 [N_OUT];
	q88_t ob_s2 [N_OUT];
	act_t hid_act [N_HIDDEN];
	act_t hid_s2 [N_HIDDEN];
	act_t out_act [N_OUT];
	act_t res0_s4, res1_s4;
	act_t res1;

	assign param_index = s_tdata[4:0];
	assign param_value = s_tdata[20:5];
	assign ins[0] = s_tdata[36:21];
	assign ins[1] = s_tdata[52:37];
	assign ins[2] = s_tdata[68:53];
	assign ins[3] = s_tdata[84:69];

	generate
		for (genvar i = 0; i < N_IN; i++) begin : g_x
			if (i < IN_FIELDS) begin : g_field
				assign x[i] = ins[i];
			end else begin : g_zero
				assign x[i] = '0;
			end
		end
	endgenerate

	assign adv = !v_s4 || m_tready;
	assign s_tready = adv;
	assign acc_w = s_tvalid && s_tready && (opcode_t'(s_tuser) == OP_WRITE);
	assign acc_c = s_tvalid && s_tready && (opcode_t'(s_tuser) == OP_INFER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WSTORE_DEPTH; k++) begin
				w_q[k] <= ONE_Q88;
			end
			for (int k = 0; k < BSTORE_DEPTH; k++) begin
				b_q[k] <= '0;
			end
		end else if (acc_w) begin
			for (int k = 0; k < WSTORE_DEPTH; k++) begin
				if (32'(param_index) == k) begin
					w_q[k] <= param_value;
				end
			end
			for (int k = 0; k < BSTORE_DEPTH; k++) begin
				if (32'(param_index) == WSTORE_DEPTH + k) begin
					b_q[k] <= param_value;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc_c;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < OW_COUNT; k++) begin
				ow_s1[k] <= w_q[HW_COUNT + k];
			end
			for (int o = 0; o < N_OUT; o++) begin
				ob_s1[o] <= b_q[N_HIDDEN + o];
			end
			ow_s2 <= ow_s1;
			ob_s2 <= ob_s1;
			hid_s2 <= hid_act;
			res0_s4 <= out_act[0];
			res1_s4 <= res1;
		end
	end

	generate
		for (genvar h = 0; h < N_HIDDEN; h++) begin : g_hid
			q88_t hw [N_IN];
			for (genvar i = 0; i < N_IN; i++) begin : g_w
				assign hw[i] = w_q[h * N_IN + i];
			end
			mlp_hid_lane u_lane (
				.clk  (clk),
				.en   (adv),
				.x    (x),
				.w    (hw),
				.bias (b_q[h]),
				.act  (hid_act[h])
			);
		end

		for (genvar o = 0; o < N_OUT; o++) begin : g_out
			q88_t lw [N_HIDDEN];
			for (genvar h = 0; h < N_HIDDEN; h++) begin : g_w
				assign lw[h] = ow_s2[o * N_HIDDEN + h];
			end
			mlp_out_lane u_lane (
				.clk  (clk),
				.en   (adv),
				.hid  (hid_s2),
				.w    (lw),
				.bias (ob_s2[o]),
				.act  (out_act[o])
			);
		end

		if (N_OUT > 1) begin : g_res1
			assign res1 = out_act[1];
		end else begin : g_res1_zero
			assign res1 = '0;
		end
	endgenerate

	assign m_tvalid = v_s4;
	assign m_tdata = {(OUT_TDATA_W - 2 * ACT_W)'(0), res1_s4, res0_s4};

	a_compute_enters: assert property (@(posedge clk) disable iff (!arst_n)
		acc_c |=> v_s1)
		else $error("accepted inference word did not enter the pipeline");

	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		acc_w |=> !v_s1)
		else $error("write word entered the pipeline");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable({v_s1, v_s2, v_s3, v_s4}))
		else $error("pipeline moved during a stall");

endmodule
